@@ design/radio_frame_checksum_deframer_unit_defines.svh @@
// Assertion macros used by the deframer top level.
`ifndef RADIO_FRAME_CHECKSUM_DEFRAMER_UNIT_DEFINES_SVH
`define RADIO_FRAME_CHECKSUM_DEFRAMER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RFCD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deframer check failed");

// The consequent must hold in the cycle after the antecedent.
`define RFCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer check failed");

`endif

@@ design/rfcd_pkg.sv @@
// Types and constants of the radio frame deframer.
`timescale 1ns / 1ps
package rfcd_pkg;

  // Byte positions within the frame header.
  localparam logic [5:0] POS_VERSION = 6'd0;
  localparam logic [5:0] POS_ID0     = 6'd1;
  localparam logic [5:0] POS_ID1     = 6'd2;
  localparam logic [5:0] POS_ID2     = 6'd3;
  localparam logic [5:0] POS_ID3     = 6'd4;
  localparam logic [5:0] POS_NUMBER  = 6'd5;
  localparam logic [5:0] POS_TYPE    = 6'd6;
  localparam logic [5:0] POS_SAT     = 6'd63;

  // Smallest legal frame: header, no payload, two checksum bytes.
  localparam int MIN_FRAME = 9;

  // Frame status codes.
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_SHORT     = 2'd1;
  localparam logic [1:0] STATUS_LONG      = 2'd2;
  localparam logic [1:0] STATUS_CHECKSUM  = 2'd3;

  // One confirmed payload byte.
  typedef struct packed {
    logic [7:0] payload_byte;
    logic [4:0] payload_index;
    logic       last_result;
  } pay_res_t;

  // End-of-frame summary.
  typedef struct packed {
    logic [7:0]  version;
    logic [31:0] device_id;
    logic [7:0]  message_number;
    logic [7:0]  message_type;
    logic [4:0]  payload_count;
    logic [1:0]  frame_status;
  } sum_res_t;

  // Everything one input byte produces.
  typedef struct packed {
    logic     pay_v;
    pay_res_t pay;
    logic     sum_v;
    sum_res_t sum;
  } step_res_t;

endpackage

@@ design/rfcd_in_if.sv @@
// Input byte channel of the deframer.
`timescale 1ns / 1ps
interface rfcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       frame_end;

  modport source (output valid, output byte_value, output frame_end, input ready);
  modport sink   (input valid, input byte_value, input frame_end, output ready);
endinterface

@@ design/rfcd_out_if.sv @@
// Result channel of the deframer.
`timescale 1ns / 1ps
interface rfcd_out_if;
  logic        valid;
  logic        ready;
  logic        is_summary;
  logic [7:0]  payload_byte;
  logic [4:0]  payload_index;
  logic [7:0]  version;
  logic [31:0] device_id;
  logic [7:0]  message_number;
  logic [7:0]  message_type;
  logic [4:0]  payload_count;
  logic [1:0]  frame_status;
  logic        last_result;

  modport source (output valid, output is_summary, output payload_byte,
                  output payload_index, output version, output device_id,
                  output message_number, output message_type, output payload_count,
                  output frame_status, output last_result, input ready);
  modport sink   (input valid, input is_summary, input payload_byte,
                  input payload_index, input version, input device_id,
                  input message_number, input message_type, input payload_count,
                  input frame_status, input last_result, output ready);
endinterface

@@ design/rfcd_core.sv @@
// Frame state and per-byte parsing, checksum and status logic.
`timescale 1ns / 1ps
module rfcd_core #(
  parameter int MAX_FRAME = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          byte_value,
  input  logic                frame_end,
  output rfcd_pkg::step_res_t res
);
  import rfcd_pkg::*;

  localparam logic [5:0] MAX_POS    = 6'(MAX_FRAME);
  localparam logic [5:0] FIRST_PAY  = 6'(MIN_FRAME);
  localparam logic [5:0] LAST_SHORT = 6'(MIN_FRAME - 1);
  localparam logic [4:0] LONG_COUNT = 5'(MAX_FRAME - MIN_FRAME);

  logic [5:0]  pos_r, pos_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic [15:0] held_r, held_nxt;
  logic [7:0]  ver_r, ver_nxt;
  logic [31:0] id_r, id_nxt;
  logic [7:0]  num_r, num_nxt;
  logic [7:0]  typ_r, typ_nxt;

  logic [7:0]  ver_cap, num_cap, typ_cap;
  logic [31:0] id_cap;
  logic        hdr_sum;
  logic        emit;
  logic [7:0]  addend;
  logic [15:0] sum_upd;
  logic [15:0] rx_sum;
  logic        is_short, is_long;
  logic [1:0]  status;
  logic [4:0]  count;

  // Capture the header field at this position.
  always_comb begin
    ver_cap = ver_r;
    id_cap  = id_r;
    num_cap = num_r;
    typ_cap = typ_r;
    hdr_sum = 1'b1;
    case (pos_r)
      POS_VERSION: ver_cap = byte_value;
      POS_ID0:     id_cap[7:0]   = byte_value;
      POS_ID1:     id_cap[15:8]  = byte_value;
      POS_ID2:     id_cap[23:16] = byte_value;
      POS_ID3:     id_cap[31:24] = byte_value;
      POS_NUMBER:  num_cap = byte_value;
      POS_TYPE: begin
        typ_cap = byte_value;
        hdr_sum = 1'b0;
      end
      default:     hdr_sum = 1'b0;
    endcase
  end

  // The byte two places back is payload once the frame runs past the header.
  assign emit    = (pos_r >= FIRST_PAY) && (pos_r < MAX_POS);
  assign addend  = hdr_sum ? byte_value : (emit ? held_r[15:8] : 8'd0);
  assign sum_upd = sum_r + {8'd0, addend};

  // Summary status from the frame length and the received checksum.
  assign rx_sum   = {byte_value, held_r[7:0]};
  assign is_short = pos_r < LAST_SHORT;
  assign is_long  = pos_r >= MAX_POS;

  always_comb begin
    if (is_short) begin
      status = STATUS_SHORT;
      count  = 5'd0;
    end else if (is_long) begin
      status = STATUS_LONG;
      count  = LONG_COUNT;
    end else begin
      status = (rx_sum == sum_upd) ? STATUS_OK : STATUS_CHECKSUM;
      count  = 5'(pos_r - LAST_SHORT);
    end
  end

  // Results for this byte.
  always_comb begin
    res.pay_v              = emit;
    res.pay.payload_byte   = held_r[15:8];
    res.pay.payload_index  = 5'(pos_r - FIRST_PAY);
    res.pay.last_result    = !frame_end;
    res.sum_v              = frame_end;
    res.sum.version        = ver_cap;
    res.sum.device_id      = id_cap;
    res.sum.message_number = num_cap;
    res.sum.message_type   = typ_cap;
    res.sum.payload_count  = count;
    res.sum.frame_status   = status;
  end

  // Next frame state: cleared after the final byte.
  always_comb begin
    pos_nxt  = pos_r;
    sum_nxt  = sum_r;
    held_nxt = held_r;
    ver_nxt  = ver_r;
    id_nxt   = id_r;
    num_nxt  = num_r;
    typ_nxt  = typ_r;
    if (step) begin
      if (frame_end) begin
        pos_nxt  = '0;
        sum_nxt  = '0;
        held_nxt = '0;
        ver_nxt  = '0;
        id_nxt   = '0;
        num_nxt  = '0;
        typ_nxt  = '0;
      end else begin
        pos_nxt  = (pos_r < POS_SAT) ? pos_r + 6'd1 : pos_r;
        sum_nxt  = sum_upd;
        held_nxt = {held_r[7:0], byte_value};
        ver_nxt  = ver_cap;
        id_nxt   = id_cap;
        num_nxt  = num_cap;
        typ_nxt  = typ_cap;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      sum_r  <= '0;
      held_r <= '0;
      ver_r  <= '0;
      id_r   <= '0;
      num_r  <= '0;
      typ_r  <= '0;
    end else begin
      pos_r  <= pos_nxt;
      sum_r  <= sum_nxt;
      held_r <= held_nxt;
      ver_r  <= ver_nxt;
      id_r   <= id_nxt;
      num_r  <= num_nxt;
      typ_r  <= typ_nxt;
    end
  end

endmodule

@@ design/radio_frame_checksum_deframer_unit.sv @@
// Top level of the radio frame deframer with its result stage.
`timescale 1ns / 1ps
`include "radio_frame_checksum_deframer_unit_defines.svh"
// Accepts one frame byte per clock while the result stage can take it, and
// presents its results in the next cycle from a two-slot result register.
// A payload byte is released two bytes after it arrives, once it cannot be
// checksum. A final byte that also releases a payload byte yields two
// transactions, payload first, and the input is then held off until the
// payload one has drained. The per-byte path is one 16-bit add followed by
// a 16-bit compare. MAX_FRAME (9 to 40) is the longest checksummed frame.
module radio_frame_checksum_deframer_unit #(
  parameter int MAX_FRAME = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  rfcd_in_if.sink    in_ch,
  rfcd_out_if.source out_ch
);
  import rfcd_pkg::*;

  step_res_t res;
  logic      accept, pop;
  logic      pay_v_r, sum_v_r;
  pay_res_t  pay_r;
  sum_res_t  sum_r;

  assign accept = in_ch.valid && in_ch.ready;
  assign pop    = out_ch.valid && out_ch.ready;

  rfcd_core #(
    .MAX_FRAME (MAX_FRAME)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (accept),
    .byte_value (in_ch.byte_value),
    .frame_end  (in_ch.frame_end),
    .res        (res)
  );

  // Take a new byte when the stage is empty or its single result leaves now.
  assign in_ch.ready = (!pay_v_r && !sum_v_r) || (out_ch.ready && (pay_v_r ^ sum_v_r));

  // Result stage slot occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pay_v_r <= 1'b0;
      sum_v_r <= 1'b0;
    end else if (accept) begin
      pay_v_r <= res.pay_v;
      sum_v_r <= res.sum_v;
    end else if (pop) begin
      if (pay_v_r) begin
        pay_v_r <= 1'b0;
      end else begin
        sum_v_r <= 1'b0;
      end
    end
  end

  // Result stage payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      pay_r <= res.pay;
      sum_r <= res.sum;
    end
  end

  // The payload slot goes out first; unused fields read as zero.
  always_comb begin
    out_ch.valid          = pay_v_r || sum_v_r;
    out_ch.is_summary     = !pay_v_r;
    out_ch.payload_byte   = pay_v_r ? pay_r.payload_byte : 8'd0;
    out_ch.payload_index  = pay_v_r ? pay_r.payload_index : 5'd0;
    out_ch.version        = pay_v_r ? 8'd0 : sum_r.version;
    out_ch.device_id      = pay_v_r ? 32'd0 : sum_r.device_id;
    out_ch.message_number = pay_v_r ? 8'd0 : sum_r.message_number;
    out_ch.message_type   = pay_v_r ? 8'd0 : sum_r.message_type;
    out_ch.payload_count  = pay_v_r ? 5'd0 : sum_r.payload_count;
    out_ch.frame_status   = pay_v_r ? STATUS_OK : sum_r.frame_status;
    out_ch.last_result    = pay_v_r ? pay_r.last_result : 1'b1;
  end

  // A full stage must hold off the input.
  `RFCD_ASSERT_NOW(a_full_blocks_input, clk, rst_n, pay_v_r && sum_v_r, !in_ch.ready)
  // A payload result followed by a summary is not the last of its byte.
  `RFCD_ASSERT_NOW(a_pay_before_sum, clk, rst_n, pay_v_r && sum_v_r, !pay_r.last_result)
  // A summary transaction always closes the results of its byte.
  `RFCD_ASSERT_NOW(a_sum_is_last, clk, rst_n, out_ch.valid && out_ch.is_summary,
                   out_ch.last_result)
  // An accepted final byte always leaves a summary in the stage.
  `RFCD_ASSERT_NEXT(a_end_gives_sum, clk, rst_n, accept && in_ch.frame_end, sum_v_r)

endmodule

@@ tb/tb_radio_frame_checksum_deframer_unit.sv @@
// Self-checking testbench of the radio frame deframer: random frames against a byte-level predictor.
`timescale 1ns / 1ps

// One result transaction as it appears on the result channel.
typedef struct packed {
  logic        is_summary;
  logic [7:0]  payload_byte;
  logic [4:0]  payload_index;
  logic [7:0]  version;
  logic [31:0] device_id;
  logic [7:0]  message_number;
  logic [7:0]  message_type;
  logic [4:0]  payload_count;
  logic [1:0]  frame_status;
  logic        last_result;
} frame_result_t;

// Predicts the deframer byte by byte and checks its results in order.
class deframe_scoreboard;
  int unsigned     max_frame;
  bit [5:0]        frame_pos;
  bit [15:0]       frame_sum;
  bit [15:0]       last_two;
  bit [7:0]        hdr_version;
  bit [31:0]       hdr_id;
  bit [7:0]        hdr_number;
  bit [7:0]        hdr_type;
  frame_result_t   expected_results[$];
  int unsigned     mismatches;

  function new(int unsigned max_frame);
    this.max_frame = max_frame;
    mismatches = 0;
    clear_frame();
  endfunction

  function void clear_frame();
    frame_pos   = '0;
    frame_sum   = '0;
    last_two    = '0;
    hdr_version = '0;
    hdr_id      = '0;
    hdr_number  = '0;
    hdr_type    = '0;
  endfunction

  function int unsigned pending();
    return expected_results.size();
  endfunction

  // Works out the results of one accepted input byte.
  function void note_byte(bit [7:0] b, bit fe);
    bit [5:0]      q;
    bit [7:0]      pb;
    bit [15:0]     rx_sum;
    int unsigned   len;
    frame_result_t r;
    q = frame_pos;

    // Header capture; every header byte but the type is summed.
    if (q == rfcd_pkg::POS_VERSION) begin
      hdr_version = b;
      frame_sum += 16'(b);
    end else if (q >= rfcd_pkg::POS_ID0 && q <= rfcd_pkg::POS_ID3) begin
      hdr_id |= 32'(b) << (8 * (q - rfcd_pkg::POS_ID0));
      frame_sum += 16'(b);
    end else if (q == rfcd_pkg::POS_NUMBER) begin
      hdr_number = b;
      frame_sum += 16'(b);
    end else if (q == rfcd_pkg::POS_TYPE) begin
      hdr_type = b;
    end

    // The byte two positions back can no longer be checksum, so it is payload.
    if (q >= rfcd_pkg::MIN_FRAME && q < max_frame) begin
      pb = last_two[15:8];
      frame_sum += 16'(pb);
      r = '0;
      r.payload_byte  = pb;
      r.payload_index = 5'(q - rfcd_pkg::MIN_FRAME);
      r.last_result   = !fe;
      expected_results.push_back(r);
    end

    if (fe) begin
      len    = q + 1;
      rx_sum = {b, last_two[7:0]};
      r = '0;
      r.is_summary     = 1'b1;
      r.version        = hdr_version;
      r.device_id      = hdr_id;
      r.message_number = hdr_number;
      r.message_type   = hdr_type;
      r.last_result    = 1'b1;
      if (len < rfcd_pkg::MIN_FRAME) begin
        r.frame_status  = rfcd_pkg::STATUS_SHORT;
        r.payload_count = '0;
      end else if (len > max_frame) begin
        r.frame_status  = rfcd_pkg::STATUS_LONG;
        r.payload_count = 5'(max_frame - rfcd_pkg::MIN_FRAME);
      end else begin
        r.payload_count = 5'(len - rfcd_pkg::MIN_FRAME);
        r.frame_status  = (rx_sum == frame_sum) ? rfcd_pkg::STATUS_OK
                                                : rfcd_pkg::STATUS_CHECKSUM;
      end
      expected_results.push_back(r);
      clear_frame();
    end else begin
      last_two = {last_two[7:0], b};
      if (q < rfcd_pkg::POS_SAT) frame_pos = 6'(q + 1);
    end
  endfunction

  function void compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      mismatches++;
    end
  endfunction

  // Compares one received transaction with the oldest expectation.
  function void check_result(frame_result_t got);
    frame_result_t want;
    if (expected_results.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %h", $time, got);
      mismatches++;
      return;
    end
    want = expected_results.pop_front();
    compare_field("is_summary", 32'(want.is_summary), 32'(got.is_summary));
    compare_field("payload_byte", 32'(want.payload_byte), 32'(got.payload_byte));
    compare_field("payload_index", 32'(want.payload_index), 32'(got.payload_index));
    compare_field("version", 32'(want.version), 32'(got.version));
    compare_field("device_id", want.device_id, got.device_id);
    compare_field("message_number", 32'(want.message_number), 32'(got.message_number));
    compare_field("message_type", 32'(want.message_type), 32'(got.message_type));
    compare_field("payload_count", 32'(want.payload_count), 32'(got.payload_count));
    compare_field("frame_status", 32'(want.frame_status), 32'(got.frame_status));
    compare_field("last_result", 32'(want.last_result), 32'(got.last_result));
  endfunction
endclass

module tb_radio_frame_checksum_deframer_unit;
  localparam int FRAME_LIMIT  = 32;
  localparam int BYTE_TARGET  = 800;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 400000;

  logic clk;
  logic rst_n;
  int unsigned cycle_count = 0;

  rfcd_in_if  in_ch ();
  rfcd_out_if out_ch ();

  deframe_scoreboard sb = new(FRAME_LIMIT);

  radio_frame_checksum_deframer_unit #(
    .MAX_FRAME(FRAME_LIMIT)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result monitor: every accepted transaction is checked.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_result('{out_ch.is_summary, out_ch.payload_byte, out_ch.payload_index,
                        out_ch.version, out_ch.device_id, out_ch.message_number,
                        out_ch.message_type, out_ch.payload_count, out_ch.frame_status,
                        out_ch.last_result});
    end
  end

  // Result sink: random stalls per transaction, with calm stretches of no stalls.
  initial begin
    int stall;
    int calm_left;
    calm_left = 0;
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (calm_left > 0) begin
        stall = 0;
        calm_left--;
      end else begin
        if ($urandom_range(0, 7) == 0) calm_left = $urandom_range(20, 60);
        stall = $urandom_range(0, 11);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(rst_n && out_ch.valid === 1'b1));
      @(negedge clk);
    end
  end

  // Sends one byte after a random gap, unless hurried, and waits until it is accepted.
  task automatic send_byte(input bit [7:0] b, input bit fe, input bit hurry);
    int gap;
    gap = hurry ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.byte_value <= b;
    in_ch.frame_end  <= fe;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_byte(b, fe);
    @(negedge clk);
  endtask

  task automatic send_frame(ref bit [7:0] f[$], input bit hurry);
    foreach (f[i]) send_byte(f[i], i == f.size() - 1, hurry);
  endtask

  // Holds the input idle until every expected result has arrived.
  task automatic wait_for_drain();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  // Writes the little-endian checksum into the last two bytes, optionally damaged.
  function automatic void seal_frame(ref bit [7:0] f[$], input bit corrupt);
    bit [15:0] s;
    bit [7:0]  mask;
    s = '0;
    for (int i = 0; i < f.size() - 2; i++) begin
      if (i != rfcd_pkg::POS_TYPE) s += 16'(f[i]);
    end
    f[f.size() - 2] = s[7:0];
    f[f.size() - 1] = s[15:8];
    if (corrupt) begin
      mask = 8'($urandom_range(1, 255));
      if ($urandom_range(0, 1)) f[f.size() - 2] ^= mask;
      else f[f.size() - 1] ^= mask;
    end
  endfunction

  // Stimulus.
  initial begin
    bit [7:0] f[$];
    int       len;
    int       pick;
    bit       corrupt;
    int       sent_bytes;
    int       frames;

    in_ch.valid      = 1'b0;
    in_ch.byte_value = '0;
    in_ch.frame_end  = 1'b0;
    rst_n            = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: a one-byte frame, a short frame of zeros, and minimum frames
    // with all-ones and all-zeros content, the second with a bad checksum.
    f = '{8'hFF};
    send_frame(f, 1'b0);
    f.delete();
    repeat (8) f.push_back(8'h00);
    send_frame(f, 1'b1);
    f.delete();
    repeat (9) f.push_back(8'hFF);
    seal_frame(f, 1'b0);
    send_frame(f, 1'b0);
    f.delete();
    repeat (9) f.push_back(8'h00);
    seal_frame(f, 1'b1);
    send_frame(f, 1'b1);
    wait_for_drain();

    // Random frames, mostly well formed with a valid checksum.
    sent_bytes = 0;
    frames     = 0;
    while (sent_bytes < BYTE_TARGET) begin
      pick    = $urandom_range(0, 99);
      corrupt = 1'b0;
      if (pick < 60) begin
        len = ($urandom_range(0, 5) == 0) ? FRAME_LIMIT
                                          : $urandom_range(rfcd_pkg::MIN_FRAME, FRAME_LIMIT);
      end else if (pick < 75) begin
        len     = $urandom_range(rfcd_pkg::MIN_FRAME, FRAME_LIMIT);
        corrupt = 1'b1;
      end else if (pick < 85) begin
        len = $urandom_range(1, rfcd_pkg::MIN_FRAME - 1);
      end else if (pick < 95) begin
        len = $urandom_range(FRAME_LIMIT + 1, FRAME_LIMIT + 8);
      end else begin
        // Long frames, some long enough for the byte position to saturate.
        len = $urandom_range(60, 70);
      end
      f.delete();
      repeat (len) f.push_back(8'($urandom));
      if (len >= rfcd_pkg::MIN_FRAME && len <= FRAME_LIMIT) seal_frame(f, corrupt);
      if (frames % 10 == 9) wait_for_drain();
      send_frame(f, $urandom_range(0, 3) == 0);
      sent_bytes += len;
      frames++;
    end

    // Let every result come out, then allow for the pipeline.
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+design
design/rfcd_pkg.sv
design/rfcd_in_if.sv
design/rfcd_out_if.sv
design/rfcd_core.sv
design/radio_frame_checksum_deframer_unit.sv
tb/tb_radio_frame_checksum_deframer_unit.sv
